FILE: rtl/ltr_pkg.sv
// Package for the two-axis light tracker: constants, register indexes,
// payload, configuration and state types. No dependencies.
`default_nettype none

package ltr_pkg;

  localparam int unsigned AngleW = 8;
  localparam int unsigned AdcW   = 10;
  localparam int unsigned StepW  = 4;
  localparam int unsigned TolW   = 10;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  // Joystick scaling value = reading * JoyMul / JoyDiv, compared via products
  localparam int unsigned JoyMul  = 180;
  localparam int unsigned JoyDiv  = 1023;
  localparam int unsigned JoyHi   = 120;
  localparam int unsigned JoyLo   = 50;
  localparam int unsigned JoyProdW = 18;
  localparam logic [JoyProdW-1:0] ProdAboveHi = JoyProdW'((JoyHi + 1) * JoyDiv);
  localparam logic [JoyProdW-1:0] ProdBelowLo = JoyProdW'(JoyLo * JoyDiv);
  localparam logic [JoyProdW-1:0] ProdBelowHi = JoyProdW'(JoyHi * JoyDiv);
  localparam logic [JoyProdW-1:0] ProdAboveLo = JoyProdW'((JoyLo + 1) * JoyDiv);

  localparam logic [AngleW-1:0] HorizMax = AngleW'(180);

  typedef enum logic [CfgIdxW-1:0] {
    CfgTolerance     = 3'd0,
    CfgAutoVertLow   = 3'd1,
    CfgAutoVertHigh  = 3'd2,
    CfgAutoHorizLow  = 3'd3,
    CfgAutoHorizHigh = 3'd4,
    CfgManVertLow    = 3'd5,
    CfgManVertHigh   = 3'd6,
    CfgJogStep       = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [TolW-1:0]   tolerance;
    logic [AngleW-1:0] auto_vert_low;
    logic [AngleW-1:0] auto_vert_high;
    logic [AngleW-1:0] auto_horiz_low;
    logic [AngleW-1:0] auto_horiz_high;
    logic [AngleW-1:0] manual_vert_low;
    logic [AngleW-1:0] manual_vert_high;
    logic [StepW-1:0]  jog_step;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    tolerance:        TolW'(50),
    auto_vert_low:    AngleW'(20),
    auto_vert_high:   AngleW'(179),
    auto_horiz_low:   AngleW'(0),
    auto_horiz_high:  AngleW'(180),
    manual_vert_low:  AngleW'(30),
    manual_vert_high: AngleW'(160),
    jog_step:         StepW'(4)
  };

  typedef struct packed {
    logic              tracking_on;
    logic              prev_button;
    logic [AngleW-1:0] jog_vert;
    logic [AngleW-1:0] jog_horiz;
    logic [AngleW-1:0] track_vert;
    logic [AngleW-1:0] track_horiz;
    logic [AngleW-1:0] cmd_vert;
    logic [AngleW-1:0] cmd_horiz;
  } state_t;

  localparam state_t StateReset = '{
    tracking_on: 1'b0,
    prev_button: 1'b0,
    jog_vert:    AngleW'(88),
    jog_horiz:   AngleW'(88),
    track_vert:  AngleW'(45),
    track_horiz: AngleW'(180),
    cmd_vert:    AngleW'(45),
    cmd_horiz:   AngleW'(180)
  };

  typedef struct packed {
    logic            button_level;
    logic [AdcW-1:0] joy_x;
    logic [AdcW-1:0] joy_y;
    logic [AdcW-1:0] light_top_left;
    logic [AdcW-1:0] light_top_right;
    logic [AdcW-1:0] light_down_left;
    logic [AdcW-1:0] light_down_right;
  } item_t;

  typedef struct packed {
    logic [AngleW-1:0] vertical_angle;
    logic [AngleW-1:0] horizontal_angle;
    logic              vertical_written;
    logic              horizontal_written;
    logic              auto_mode;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/ltr_if.sv
// Channel interfaces of the light tracker: sensor tick input, angle result
// and configuration write. Depends on ltr_pkg.
`default_nettype none

interface ltr_in_if;
  logic                       valid;
  logic                       ready;
  logic                       button_level;
  logic [ltr_pkg::AdcW-1:0]   joy_x;
  logic [ltr_pkg::AdcW-1:0]   joy_y;
  logic [ltr_pkg::AdcW-1:0]   light_top_left;
  logic [ltr_pkg::AdcW-1:0]   light_top_right;
  logic [ltr_pkg::AdcW-1:0]   light_down_left;
  logic [ltr_pkg::AdcW-1:0]   light_down_right;

  modport source (
    output valid, button_level, joy_x, joy_y, light_top_left, light_top_right,
           light_down_left, light_down_right,
    input  ready
  );
  modport sink (
    input  valid, button_level, joy_x, joy_y, light_top_left, light_top_right,
           light_down_left, light_down_right,
    output ready
  );
endinterface

interface ltr_out_if;
  logic                       valid;
  logic                       ready;
  logic [ltr_pkg::AngleW-1:0] vertical_angle;
  logic [ltr_pkg::AngleW-1:0] horizontal_angle;
  logic                       vertical_written;
  logic                       horizontal_written;
  logic                       auto_mode;

  modport source (
    output valid, vertical_angle, horizontal_angle, vertical_written,
           horizontal_written, auto_mode,
    input  ready
  );
  modport sink (
    input  valid, vertical_angle, horizontal_angle, vertical_written,
           horizontal_written, auto_mode,
    output ready
  );
endinterface

interface ltr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ltr_pkg::CfgIdxW-1:0]  index;
  logic [ltr_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/ltr_step.sv
// One control tick of the tracker: mode toggle, manual jog and auto light
// tracking, giving next state and result. Depends on ltr_pkg.
`default_nettype none

module ltr_step (
  input  ltr_pkg::state_t state_i,
  input  ltr_pkg::cfg_t   cfg_i,
  input  ltr_pkg::item_t  item_i,
  output ltr_pkg::state_t state_o,
  output ltr_pkg::res_t   res_o
);

  localparam int unsigned MoveW = ltr_pkg::AngleW + 2;

  logic                            mode;
  logic [ltr_pkg::JoyProdW-1:0]    prod_x, prod_y;
  logic                            v_up, v_dn, h_add, h_sub;
  logic signed [MoveW-1:0]         step_s, jv_mov, jh_mov, tv_mov, th_mov;
  logic [ltr_pkg::AngleW-1:0]      jv_new, jh_new, tv_new, th_new;
  logic [ltr_pkg::AdcW:0]          sum_t, sum_d, sum_l, sum_r;
  logic [ltr_pkg::AdcW-1:0]        av_t, av_d, av_l, av_r;
  logic [ltr_pkg::AdcW-1:0]        dv_mag, dh_mag;
  logic                            v_out, h_out;

  assign mode = state_i.tracking_on ^ (item_i.button_level & ~state_i.prev_button);

  assign prod_x = ltr_pkg::JoyProdW'(item_i.joy_x) * ltr_pkg::JoyProdW'(ltr_pkg::JoyMul);
  assign prod_y = ltr_pkg::JoyProdW'(item_i.joy_y) * ltr_pkg::JoyProdW'(ltr_pkg::JoyMul);
  assign v_up   = prod_y >= ltr_pkg::ProdAboveHi;
  assign v_dn   = prod_y <  ltr_pkg::ProdBelowLo;
  assign h_add  = prod_x <  ltr_pkg::ProdBelowHi;
  assign h_sub  = prod_x >= ltr_pkg::ProdAboveLo;
  assign step_s = $signed(MoveW'(cfg_i.jog_step));

  assign sum_t = {1'b0, item_i.light_top_left} + {1'b0, item_i.light_top_right};
  assign sum_d = {1'b0, item_i.light_down_left} + {1'b0, item_i.light_down_right};
  assign sum_l = {1'b0, item_i.light_top_left} + {1'b0, item_i.light_down_left};
  assign sum_r = {1'b0, item_i.light_top_right} + {1'b0, item_i.light_down_right};
  assign av_t  = sum_t[ltr_pkg::AdcW:1];
  assign av_d  = sum_d[ltr_pkg::AdcW:1];
  assign av_l  = sum_l[ltr_pkg::AdcW:1];
  assign av_r  = sum_r[ltr_pkg::AdcW:1];
  assign dv_mag = (av_t > av_d) ? (av_t - av_d) : (av_d - av_t);
  assign dh_mag = (av_l > av_r) ? (av_l - av_r) : (av_r - av_l);
  assign v_out  = dv_mag > cfg_i.tolerance;
  assign h_out  = dh_mag > cfg_i.tolerance;

  // manual jog
  always_comb begin
    jv_mov = $signed(MoveW'(state_i.jog_vert));
    if (v_up) begin
      jv_mov = jv_mov + step_s;
    end
    if (v_dn) begin
      jv_mov = jv_mov - step_s;
    end
    if (jv_mov < $signed(MoveW'(cfg_i.manual_vert_low))) begin
      jv_new = cfg_i.manual_vert_low;
    end else if (jv_mov > $signed(MoveW'(cfg_i.manual_vert_high))) begin
      jv_new = cfg_i.manual_vert_high;
    end else begin
      jv_new = jv_mov[ltr_pkg::AngleW-1:0];
    end

    jh_mov = $signed(MoveW'(state_i.jog_horiz));
    if (h_add) begin
      jh_mov = jh_mov + step_s;
    end
    if (h_sub) begin
      jh_mov = jh_mov - step_s;
    end
    if (jh_mov < $signed(MoveW'(0))) begin
      jh_new = '0;
    end else if (jh_mov > $signed(MoveW'(ltr_pkg::HorizMax))) begin
      jh_new = ltr_pkg::HorizMax;
    end else begin
      jh_new = jh_mov[ltr_pkg::AngleW-1:0];
    end
  end

  // auto tracking, one degree per tick
  always_comb begin
    tv_mov = $signed(MoveW'(state_i.track_vert));
    tv_new = state_i.track_vert;
    if (av_t > av_d) begin
      tv_mov = tv_mov + $signed(MoveW'(1));
      if (tv_mov > $signed(MoveW'(cfg_i.auto_vert_high))) begin
        tv_new = cfg_i.auto_vert_high;
      end else begin
        tv_new = tv_mov[ltr_pkg::AngleW-1:0];
      end
    end else if (av_t < av_d) begin
      tv_mov = tv_mov - $signed(MoveW'(1));
      if (tv_mov < $signed(MoveW'(cfg_i.auto_vert_low))) begin
        tv_new = cfg_i.auto_vert_low;
      end else begin
        tv_new = tv_mov[ltr_pkg::AngleW-1:0];
      end
    end

    th_mov = $signed(MoveW'(state_i.track_horiz));
    th_new = state_i.track_horiz;
    if (av_l > av_r) begin
      th_mov = th_mov - $signed(MoveW'(1));
      if (th_mov < $signed(MoveW'(cfg_i.auto_horiz_low))) begin
        th_new = cfg_i.auto_horiz_low;
      end else begin
        th_new = th_mov[ltr_pkg::AngleW-1:0];
      end
    end else if (av_l < av_r) begin
      th_mov = th_mov + $signed(MoveW'(1));
      if (th_mov > $signed(MoveW'(cfg_i.auto_horiz_high))) begin
        th_new = cfg_i.auto_horiz_high;
      end else begin
        th_new = th_mov[ltr_pkg::AngleW-1:0];
      end
    end
  end

  always_comb begin
    state_o             = state_i;
    state_o.tracking_on = mode;
    state_o.prev_button = item_i.button_level;
    res_o.vertical_written   = 1'b0;
    res_o.horizontal_written = 1'b0;
    if (!mode) begin
      state_o.jog_vert  = jv_new;
      state_o.jog_horiz = jh_new;
      state_o.cmd_vert  = jv_new;
      state_o.cmd_horiz = jh_new;
      res_o.vertical_written   = 1'b1;
      res_o.horizontal_written = 1'b1;
    end else begin
      if (v_out) begin
        state_o.track_vert = tv_new;
        state_o.cmd_vert   = tv_new;
        res_o.vertical_written = 1'b1;
      end
      if (h_out) begin
        state_o.track_horiz = th_new;
        state_o.cmd_horiz   = th_new;
        res_o.horizontal_written = 1'b1;
      end
    end
    res_o.vertical_angle   = state_o.cmd_vert;
    res_o.horizontal_angle = state_o.cmd_horiz;
    res_o.auto_mode        = mode;
  end

endmodule

`default_nettype wire

FILE: rtl/two_axis_light_tracker_with_manual_jog.sv
// Two-axis light tracker with manual joystick jog.
// A tick is captured in the input register, the state update works on it, and
// its result is held in the result register that drives out_o.
// Throughput: one tick per cycle unless out_o stalls; input register and result
// register each hold one transaction, the state update sits between them.
// Reset: rst_ni async low clears state to manual mode and registers to defaults.
// Depends on ltr_pkg, ltr_if and ltr_step.
`default_nettype none

module two_axis_light_tracker_with_manual_jog (
  input  wire         clk_i,
  input  wire         rst_ni,
  ltr_in_if.sink      in_i,
  ltr_cfg_if.sink     cfg_i,
  ltr_out_if.source   out_o
);

  ltr_pkg::cfg_t   cfg_q;
  ltr_pkg::state_t state_q, state_d;
  ltr_pkg::item_t  item_q, item_in;
  ltr_pkg::res_t   res_q, res_d;
  logic            in_valid_q, out_valid_q;
  logic            advance, in_take;

  assign advance = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign item_in = '{
    button_level:     in_i.button_level,
    joy_x:            in_i.joy_x,
    joy_y:            in_i.joy_y,
    light_top_left:   in_i.light_top_left,
    light_top_right:  in_i.light_top_right,
    light_down_left:  in_i.light_down_left,
    light_down_right: in_i.light_down_right
  };

  ltr_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .item_i  (item_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ltr_pkg::CfgReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (ltr_pkg::cfg_reg_e'(cfg_i.index))
        ltr_pkg::CfgTolerance:     cfg_q.tolerance <= cfg_i.data;
        ltr_pkg::CfgAutoVertLow:   cfg_q.auto_vert_low <= cfg_i.data[ltr_pkg::AngleW-1:0];
        ltr_pkg::CfgAutoVertHigh:  cfg_q.auto_vert_high <= cfg_i.data[ltr_pkg::AngleW-1:0];
        ltr_pkg::CfgAutoHorizLow:  cfg_q.auto_horiz_low <= cfg_i.data[ltr_pkg::AngleW-1:0];
        ltr_pkg::CfgAutoHorizHigh: cfg_q.auto_horiz_high <= cfg_i.data[ltr_pkg::AngleW-1:0];
        ltr_pkg::CfgManVertLow:    cfg_q.manual_vert_low <= cfg_i.data[ltr_pkg::AngleW-1:0];
        ltr_pkg::CfgManVertHigh:   cfg_q.manual_vert_high <= cfg_i.data[ltr_pkg::AngleW-1:0];
        ltr_pkg::CfgJogStep:       cfg_q.jog_step <= cfg_i.data[ltr_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ltr_pkg::StateReset;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_in;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.vertical_angle     = res_q.vertical_angle;
  assign out_o.horizontal_angle   = res_q.horizontal_angle;
  assign out_o.vertical_written   = res_q.vertical_written;
  assign out_o.horizontal_written = res_q.horizontal_written;
  assign out_o.auto_mode          = res_q.auto_mode;

  a_mode_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q.tracking_on))
    else $error("mode changed without a processed tick");

  a_manual_writes_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.auto_mode |->
      out_o.vertical_written && out_o.horizontal_written)
    else $error("manual result missing a servo command");

  a_manual_horiz_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.auto_mode |-> out_o.horizontal_angle <= ltr_pkg::HorizMax)
    else $error("manual horizontal angle out of range");

  a_result_follows_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q && (res_q.auto_mode == state_q.tracking_on))
    else $error("result does not match updated mode");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the two-axis light tracker with manual jog.
// Drives sensor ticks and register writes, predicts every result in a scoreboard.
// Depends on ltr_pkg, ltr_if and the tracker RTL.
module tb;

  localparam int DegFull    = 180;
  localparam int AdcFull    = 1023;
  localparam int JogUpDeg   = 120;
  localparam int JogDownDeg = 50;
  localparam int PhaseTicks = 110;
  localparam int NumPhases  = 12;

  typedef enum int {StallNone, StallCoin, StallSparse, StallBlock} stall_e;

  class tracker_scoreboard;
    ltr_pkg::res_t expected_q[$];
    int   n_mismatch, n_ticks, n_auto;
    bit   auto_on, prev_btn;
    int   jog_v, jog_h, trk_v, trk_h, cmd_v, cmd_h;
    int   tol, a_vlo, a_vhi, a_hlo, a_hhi, m_vlo, m_vhi, step;

    function new();
      auto_on = 1'b0;
      prev_btn = 1'b0;
      jog_v = 88;
      jog_h = 88;
      trk_v = 45;
      trk_h = 180;
      cmd_v = 45;
      cmd_h = 180;
      tol   = int'(ltr_pkg::CfgReset.tolerance);
      a_vlo = int'(ltr_pkg::CfgReset.auto_vert_low);
      a_vhi = int'(ltr_pkg::CfgReset.auto_vert_high);
      a_hlo = int'(ltr_pkg::CfgReset.auto_horiz_low);
      a_hhi = int'(ltr_pkg::CfgReset.auto_horiz_high);
      m_vlo = int'(ltr_pkg::CfgReset.manual_vert_low);
      m_vhi = int'(ltr_pkg::CfgReset.manual_vert_high);
      step  = int'(ltr_pkg::CfgReset.jog_step);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(ltr_pkg::cfg_reg_e idx, logic [ltr_pkg::CfgDataW-1:0] val);
      case (idx)
        ltr_pkg::CfgTolerance:     tol   = int'(val);
        ltr_pkg::CfgAutoVertLow:   a_vlo = int'(val[7:0]);
        ltr_pkg::CfgAutoVertHigh:  a_vhi = int'(val[7:0]);
        ltr_pkg::CfgAutoHorizLow:  a_hlo = int'(val[7:0]);
        ltr_pkg::CfgAutoHorizHigh: a_hhi = int'(val[7:0]);
        ltr_pkg::CfgManVertLow:    m_vlo = int'(val[7:0]);
        ltr_pkg::CfgManVertHigh:   m_vhi = int'(val[7:0]);
        ltr_pkg::CfgJogStep:       step  = int'(val[3:0]);
        default: ;
      endcase
    endfunction

    function void note_tick(ltr_pkg::item_t it);
      int   vx, vy, avg_t, avg_d, avg_l, avg_r, dv, dh;
      ltr_pkg::res_t r;
      r = '0;
      if (!prev_btn && it.button_level) auto_on = !auto_on;
      prev_btn = it.button_level;
      if (!auto_on) begin
        vy = int'(it.joy_y) * DegFull / AdcFull;
        vx = int'(it.joy_x) * DegFull / AdcFull;
        if (vy > JogUpDeg) jog_v += step;
        if (vy < JogDownDeg) jog_v -= step;
        if (jog_v < m_vlo) jog_v = m_vlo;
        else if (jog_v > m_vhi) jog_v = m_vhi;
        cmd_v = jog_v;
        r.vertical_written = 1'b1;
        if (vx < JogUpDeg) jog_h += step;
        if (vx > JogDownDeg) jog_h -= step;
        if (jog_h < 0) jog_h = 0;
        else if (jog_h > DegFull) jog_h = DegFull;
        cmd_h = jog_h;
        r.horizontal_written = 1'b1;
      end else begin
        n_auto++;
        avg_t = (int'(it.light_top_left) + int'(it.light_top_right)) / 2;
        avg_d = (int'(it.light_down_left) + int'(it.light_down_right)) / 2;
        avg_l = (int'(it.light_top_left) + int'(it.light_down_left)) / 2;
        avg_r = (int'(it.light_top_right) + int'(it.light_down_right)) / 2;
        dv = avg_t - avg_d;
        dh = avg_l - avg_r;
        if (dv < -tol || dv > tol) begin
          if (avg_t > avg_d) begin
            trk_v++;
            if (trk_v > a_vhi) trk_v = a_vhi;
          end else if (avg_t < avg_d) begin
            trk_v--;
            if (trk_v < a_vlo) trk_v = a_vlo;
          end
          cmd_v = trk_v;
          r.vertical_written = 1'b1;
        end
        if (dh < -tol || dh > tol) begin
          if (avg_l > avg_r) begin
            trk_h--;
            if (trk_h < a_hlo) trk_h = a_hlo;
          end else if (avg_l < avg_r) begin
            trk_h++;
            if (trk_h > a_hhi) trk_h = a_hhi;
          end
          cmd_h = trk_h;
          r.horizontal_written = 1'b1;
        end
      end
      r.vertical_angle   = 8'(cmd_v);
      r.horizontal_angle = 8'(cmd_h);
      r.auto_mode        = auto_on;
      n_ticks++;
      expected_q.push_back(r);
    endfunction

    function void cmp_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        n_mismatch++;
      end
    endfunction

    function void check_result(ltr_pkg::res_t got);
      ltr_pkg::res_t e;
      if (expected_q.size() == 0) begin
        $error("result with no tick pending: v=%0d h=%0d", got.vertical_angle,
               got.horizontal_angle);
        n_mismatch++;
        return;
      end
      e = expected_q.pop_front();
      cmp_field("vertical_angle", e.vertical_angle, got.vertical_angle);
      cmp_field("horizontal_angle", e.horizontal_angle, got.horizontal_angle);
      cmp_field("vertical_written", 8'(e.vertical_written), 8'(got.vertical_written));
      cmp_field("horizontal_written", 8'(e.horizontal_written),
                8'(got.horizontal_written));
      cmp_field("auto_mode", 8'(e.auto_mode), 8'(got.auto_mode));
    endfunction
  endclass

  logic clk;
  logic rst_ni;

  ltr_in_if  in_if ();
  ltr_cfg_if cfg_if ();
  ltr_out_if out_if ();

  two_axis_light_tracker_with_manual_jog uut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  tracker_scoreboard sb;
  int            burst_left;
  bit            steady;
  int            n_cfg;
  logic          btn_lvl;
  logic [9:0]    jx_hold, jy_hold;
  int            sun_v, sun_h, sun_s, sun_left;
  ltr_pkg::res_t got_res;

  assign got_res = '{vertical_angle:     out_if.vertical_angle,
                     horizontal_angle:   out_if.horizontal_angle,
                     vertical_written:   out_if.vertical_written,
                     horizontal_written: out_if.horizontal_written,
                     auto_mode:          out_if.auto_mode};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

  // receiver stall pattern
  initial begin
    stall_e sm;
    int     len;
    out_if.ready <= 1'b0;
    forever begin
      sm  = stall_e'($urandom_range(0, 3));
      len = $urandom_range(16, 160);
      for (int k = 0; k < len; k++) begin
        @(posedge clk);
        case (sm)
          StallNone:   out_if.ready <= 1'b1;
          StallCoin:   out_if.ready <= 1'($urandom_range(0, 1));
          StallSparse: out_if.ready <= (k % 7) != 3;
          default:     out_if.ready <= (k % 11) < 4;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(got_res);
  end

  function automatic ltr_pkg::item_t mk(logic btn, int jx, int jy, int tl, int tr,
                                        int dl, int dr);
    ltr_pkg::item_t it;
    it.button_level     = btn;
    it.joy_x            = 10'(jx);
    it.joy_y            = 10'(jy);
    it.light_top_left   = 10'(tl);
    it.light_top_right  = 10'(tr);
    it.light_down_left  = 10'(dl);
    it.light_down_right = 10'(dr);
    return it;
  endfunction

  function automatic logic [9:0] adc_clip(int v);
    if (v < 0) return 10'd0;
    if (v > AdcFull) return 10'(AdcFull);
    return 10'(v);
  endfunction

  // extremes, values around the scaling thresholds, or anything
  function automatic logic [9:0] pick_joy();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 10'd0 : 10'(AdcFull);
      1: return $urandom_range(0, 1) ? 10'($urandom_range(280, 292))
                                     : 10'($urandom_range(678, 692));
      default: return 10'($urandom);
    endcase
  endfunction

  // button held for stretches; light pattern follows a slowly moving sun
  function automatic ltr_pkg::item_t random_tick();
    ltr_pkg::item_t it;
    int    base, off_v, off_h;
    if ($urandom_range(0, 11) == 0) btn_lvl = ~btn_lvl;
    if (sun_left == 0) begin
      sun_v    = int'($urandom_range(0, 2)) - 1;
      sun_h    = int'($urandom_range(0, 2)) - 1;
      sun_s    = $urandom_range(0, 160);
      sun_left = $urandom_range(8, 40);
    end
    sun_left--;
    if ($urandom_range(0, 1) == 0) begin
      jx_hold = pick_joy();
      jy_hold = pick_joy();
    end
    it.button_level = btn_lvl;
    it.joy_x        = jx_hold;
    it.joy_y        = jy_hold;
    if ($urandom_range(0, 7) == 0) begin
      it.light_top_left   = 10'($urandom);
      it.light_top_right  = 10'($urandom);
      it.light_down_left  = 10'($urandom);
      it.light_down_right = 10'($urandom);
    end else begin
      base = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 0 : AdcFull)
                                         : int'($urandom_range(200, 823));
      off_v = sun_v * sun_s;
      off_h = sun_h * sun_s;
      it.light_top_left   = adc_clip(base + off_v - off_h + int'($urandom_range(0, 16)) - 8);
      it.light_top_right  = adc_clip(base + off_v + off_h + int'($urandom_range(0, 16)) - 8);
      it.light_down_left  = adc_clip(base - off_v - off_h + int'($urandom_range(0, 16)) - 8);
      it.light_down_right = adc_clip(base - off_v + off_h + int'($urandom_range(0, 16)) - 8);
    end
    return it;
  endfunction

  task automatic send_tick(ltr_pkg::item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_if.valid            <= 1'b1;
    in_if.button_level     <= it.button_level;
    in_if.joy_x            <= it.joy_x;
    in_if.joy_y            <= it.joy_y;
    in_if.light_top_left   <= it.light_top_left;
    in_if.light_top_right  <= it.light_top_right;
    in_if.light_down_left  <= it.light_down_left;
    in_if.light_down_right <= it.light_down_right;
    do @(posedge clk); while (!in_if.ready);
    sb.note_tick(it);
  endtask

  task automatic write_reg(ltr_pkg::cfg_reg_e idx, logic [ltr_pkg::CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, val);
    n_cfg++;
  endtask

  task automatic write_set(int tol, int avlo, int avhi, int ahlo, int ahhi,
                           int mvlo, int mvhi, int stp);
    write_reg(ltr_pkg::CfgTolerance, 10'(tol));
    write_reg(ltr_pkg::CfgAutoVertLow, 10'(avlo));
    write_reg(ltr_pkg::CfgAutoVertHigh, 10'(avhi));
    write_reg(ltr_pkg::CfgAutoHorizLow, 10'(ahlo));
    write_reg(ltr_pkg::CfgAutoHorizHigh, 10'(ahhi));
    write_reg(ltr_pkg::CfgManVertLow, 10'(mvlo));
    write_reg(ltr_pkg::CfgManVertHigh, 10'(mvhi));
    write_reg(ltr_pkg::CfgJogStep, 10'(stp));
  endtask

  // drain: input idle, wait until all results are back, then let the pipeline settle
  task automatic drain();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic setup_phase(int p);
    ltr_pkg::cfg_reg_e r;
    case (p)
      1: write_set(0, 0, 180, 0, 180, 0, 180, 15);
      2: write_set(1023, 0, 255, 0, 255, 0, 255, 0);
      3: write_set(5, 170, 10, 150, 30, 150, 40, 7);
      NumPhases: write_set(ltr_pkg::CfgReset.tolerance, ltr_pkg::CfgReset.auto_vert_low,
                           ltr_pkg::CfgReset.auto_vert_high,
                           ltr_pkg::CfgReset.auto_horiz_low,
                           ltr_pkg::CfgReset.auto_horiz_high,
                           ltr_pkg::CfgReset.manual_vert_low,
                           ltr_pkg::CfgReset.manual_vert_high,
                           ltr_pkg::CfgReset.jog_step);
      default: begin
        for (int i = 0; i < 8; i++) begin
          r = ltr_pkg::cfg_reg_e'(i);
          if (i == 0 || $urandom_range(0, 2) != 0) begin
            case (r)
              ltr_pkg::CfgTolerance:
                write_reg(r, ($urandom_range(0, 3) == 0) ? 10'($urandom)
                                                         : 10'($urandom_range(0, 120)));
              ltr_pkg::CfgAutoVertLow, ltr_pkg::CfgAutoHorizLow, ltr_pkg::CfgManVertLow:
                write_reg(r, {2'($urandom), ($urandom_range(0, 4) == 0)
                              ? 8'($urandom) : 8'($urandom_range(0, 90))});
              ltr_pkg::CfgAutoVertHigh, ltr_pkg::CfgAutoHorizHigh,
              ltr_pkg::CfgManVertHigh:
                write_reg(r, {2'($urandom), ($urandom_range(0, 4) == 0)
                              ? 8'($urandom) : 8'($urandom_range(90, 180))});
              default: write_reg(r, 10'($urandom));
            endcase
          end
        end
      end
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    burst_left = 0;
    steady     = 1'b0;
    n_cfg      = 0;
    btn_lvl    = 1'b0;
    jx_hold    = 10'd512;
    jy_hold    = 10'd512;
    sun_left   = 0;
    rst_ni                 <= 1'b0;
    in_if.valid            <= 1'b0;
    in_if.button_level     <= 1'b0;
    in_if.joy_x            <= '0;
    in_if.joy_y            <= '0;
    in_if.light_top_left   <= '0;
    in_if.light_top_right  <= '0;
    in_if.light_down_left  <= '0;
    in_if.light_down_right <= '0;
    cfg_if.valid           <= 1'b0;
    cfg_if.index           <= ltr_pkg::CfgTolerance;
    cfg_if.data            <= '0;
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // manual jog: extremes and the scaling thresholds
    send_tick(mk(0, 0, 0, 0, 0, 0, 0));
    send_tick(mk(0, 1023, 1023, 1023, 1023, 1023, 1023));
    send_tick(mk(0, 682, 682, 5, 900, 17, 333));
    send_tick(mk(0, 688, 688, 0, 0, 0, 0));
    send_tick(mk(0, 285, 285, 0, 0, 0, 0));
    send_tick(mk(0, 290, 284, 0, 0, 0, 0));
    // rising edge into auto tracking
    send_tick(mk(1, 0, 1023, 512, 512, 512, 512));
    send_tick(mk(1, 0, 0, 151, 151, 100, 100));
    send_tick(mk(1, 0, 0, 150, 150, 100, 100));
    send_tick(mk(1, 0, 0, 100, 100, 200, 200));
    send_tick(mk(1, 0, 0, 300, 100, 300, 100));
    send_tick(mk(1, 0, 0, 100, 400, 100, 400));
    send_tick(mk(1, 0, 0, 1023, 1023, 1023, 1023));
    send_tick(mk(1, 0, 0, 1023, 1022, 0, 1));
    send_tick(mk(1, 0, 0, 0, 0, 1023, 1023));
    // falling edge keeps the mode, next rising edge back to manual
    send_tick(mk(0, 1023, 0, 700, 10, 600, 20));
    send_tick(mk(1, 1023, 1023, 0, 0, 0, 0));
    send_tick(mk(1, 0, 0, 0, 0, 0, 0));
    send_tick(mk(0, 512, 512, 0, 0, 0, 0));

    for (int p = 1; p <= NumPhases; p++) begin
      drain();
      setup_phase(p);
      steady = (p % 4 == 0);
      repeat (PhaseTicks) send_tick(random_tick());
    end
    drain();

    $display("tb: %0d ticks checked (%0d in auto tracking), %0d register writes",
             sb.n_ticks, sb.n_auto, n_cfg);
    $display("tb: %0d register settings incl. extremes and crossed limits", NumPhases + 1);
    if (sb.n_mismatch == 0 && sb.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
